FILE: rtl/core/bdm_pkg.sv
// Shared types, constants and arithmetic helpers for the Bayer demosaic block.
// No dependencies; every other file of the block imports this package.
package bdm_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_BITS   = 16;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = 12;
    localparam int HGT_W      = 13;
    localparam int IN_ROW_W   = 13;
    localparam int OUT_ROW_W  = 12;
    localparam int LEAD_W     = 13;
    localparam int SMP_W      = 16;
    localparam int WIN_N      = 5;
    localparam int SUM_W      = 22;
    localparam int BITS_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_METHOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BITS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd4;

    localparam logic [1:0] METH_RAW   = 2'd0;
    localparam logic [1:0] METH_BILIN = 2'd1;

    typedef enum logic [1:0] {
        CLR_R,
        CLR_G,
        CLR_B
    } t_color;

    typedef logic [SMP_W-1:0]   t_smp;
    // one window column, index 0 is the top row
    typedef t_smp  [WIN_N-1:0]  t_column;
    // index 0 is the newest column (rightmost tap)
    typedef t_column [WIN_N-1:0] t_window;

    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic             flush;
    } t_in_word;

    typedef struct packed {
        logic [SMP_W-1:0] red;
        logic [SMP_W-1:0] green;
        logic [SMP_W-1:0] blue;
        logic             last_of_frame;
    } t_out_word;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [1:0]       pattern;
        logic [1:0]       method;
        logic [SMP_W-1:0] mx;
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic signed [SUM_W-1:0] gn;
        logic signed [SUM_W-1:0] on;
        logic signed [SUM_W-1:0] dgn;
        logic signed [SUM_W-1:0] doxn;
        logic signed [SUM_W-1:0] hn;
        logic signed [SUM_W-1:0] vn;
        logic signed [SUM_W-1:0] dhn;
        logic signed [SUM_W-1:0] dvn;
    } t_sums;

    function automatic t_color f_cfa(input logic [1:0] pattern, input logic yodd,
                                     input logic xodd);
        t_color c;
        c = CLR_G;
        case (pattern)
            2'd0: c = (!yodd && !xodd) ? CLR_R : ((yodd && xodd) ? CLR_B : CLR_G);
            2'd1: c = (!yodd &&  xodd) ? CLR_R : ((yodd && !xodd) ? CLR_B : CLR_G);
            2'd2: c = (!yodd && !xodd) ? CLR_B : ((yodd && xodd) ? CLR_R : CLR_G);
            2'd3: c = (!yodd &&  xodd) ? CLR_B : ((yodd && !xodd) ? CLR_R : CLR_G);
            default: c = CLR_G;
        endcase
        return c;
    endfunction

    function automatic logic signed [SUM_W-1:0] f_sx(input logic [SMP_W-1:0] v);
        return $signed({{(SUM_W-SMP_W){1'b0}}, v});
    endfunction

    // arithmetic shift right that rounds toward zero
    function automatic logic signed [SUM_W-1:0] f_div_tz(input logic signed [SUM_W-1:0] v,
                                                         input int k);
        logic signed [SUM_W-1:0] bias;
        bias = v[SUM_W-1] ? ((SUM_W'(1) <<< k) - SUM_W'(1)) : '0;
        return (v + bias) >>> k;
    endfunction

    function automatic logic [SMP_W-1:0] f_clamp(input logic signed [SUM_W-1:0] v,
                                                 input logic [SMP_W-1:0] mx);
        logic [SMP_W-1:0] r;
        if (v[SUM_W-1]) begin
            r = '0;
        end else if (v > f_sx(mx)) begin
            r = mx;
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/bdm_line_store.sv
// Four-line sample store: one word per column holding the four previous rows.
// Depends on bdm_pkg. Read data registered, write-to-read forwarding included.
module bdm_line_store (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_rd,
    input  logic [bdm_pkg::COL_W-1:0] i_rd_addr,
    input  logic                 i_wr,
    input  logic [bdm_pkg::COL_W-1:0] i_wr_addr,
    input  logic [bdm_pkg::SMP_W-1:0] i_wr_sample,
    output bdm_pkg::t_column     o_column
);
    import bdm_pkg::*;

    localparam int WORD_W = 4 * SMP_W;

    logic [WORD_W-1:0] r_mem [MAX_WIDTH];
    logic [WORD_W-1:0] r_rd;
    logic [WORD_W-1:0] r_byp_word;
    logic              r_byp;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] wword;

    // low slot is the row just above, high slot the row four up
    assign cur   = r_byp ? r_byp_word : r_rd;
    assign wword = {cur[3*SMP_W-1:0], i_wr_sample};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_rd) begin
                r_rd       <= r_mem[i_rd_addr];
                r_byp      <= i_wr && (i_wr_addr == i_rd_addr);
                r_byp_word <= wword;
            end
            if (i_wr) begin
                r_mem[i_wr_addr] <= wword;
            end
        end
    end

    assign o_column[0] = cur[4*SMP_W-1:3*SMP_W];
    assign o_column[1] = cur[3*SMP_W-1:2*SMP_W];
    assign o_column[2] = cur[2*SMP_W-1:SMP_W];
    assign o_column[3] = cur[SMP_W-1:0];
    assign o_column[4] = i_wr_sample;

endmodule

FILE: rtl/core/bdm_cell.sv
// One window column cell: holds five vertical samples, passes them on per word.
// Depends on bdm_pkg.
module bdm_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  bdm_pkg::t_column i_column,
    output bdm_pkg::t_column o_column
);
    import bdm_pkg::*;

    t_column r_column;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_column <= i_column;
        end
    end

    assign o_column = r_column;

endmodule

FILE: rtl/core/bdm_filter.sv
// Interpolation datapath: edge masking and tap sums, then rounding, clamping
// and channel selection into the output register. Depends on bdm_pkg.
module bdm_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [bdm_pkg::COL_W-1:0]     i_x,
    input  logic [bdm_pkg::OUT_ROW_W-1:0] i_y,
    input  logic                          i_last,
    input  bdm_pkg::t_window              i_win,
    input  bdm_pkg::t_cfg                 i_cfg,
    output logic                          o_valid,
    output bdm_pkg::t_out_word            o_word
);
    import bdm_pkg::*;

    logic [SMP_W-1:0] p [WIN_N][WIN_N];
    logic [13:0]      tx [WIN_N];
    logic [13:0]      ty [WIN_N];
    logic [WIN_N-1:0] colok;
    logic [WIN_N-1:0] rowok;
    t_sums            sums;

    t_sums            r_c_sums;
    logic             r_c_valid;
    logic [SMP_W-1:0] r_c_ctr;
    t_color           r_c_color;
    logic             r_c_red_row;
    logic [1:0]       r_c_method;
    logic [SMP_W-1:0] r_c_mx;
    logic             r_c_last;

    logic             r_out_valid;
    t_out_word        r_out_word;
    t_out_word        n_out_word;

    always_comb begin
        for (int j = 0; j < WIN_N; j++) begin
            tx[j]    = 14'({3'b0, i_x}) + 14'(j) - 14'd2;
            colok[j] = !tx[j][13] && (tx[j] < 14'({2'b0, i_cfg.width}));
            ty[j]    = 14'({2'b0, i_y}) + 14'(j) - 14'd2;
            rowok[j] = !ty[j][13] && (ty[j] < 14'({1'b0, i_cfg.height}));
        end
        // p[row][col], row/col 2 is the center; cell 0 holds the rightmost column
        for (int i = 0; i < WIN_N; i++) begin
            for (int j = 0; j < WIN_N; j++) begin
                p[i][j] = (rowok[i] && colok[j]) ? (i_win[WIN_N-1-j][i] & i_cfg.mx) : '0;
            end
        end
    end

    always_comb begin
        sums.gn   = f_sx(p[2][1]) + f_sx(p[2][3]) + f_sx(p[1][2]) + f_sx(p[3][2])
                  + SUM_W'(2);
        sums.on   = f_sx(p[1][1]) + f_sx(p[1][3]) + f_sx(p[3][1]) + f_sx(p[3][3])
                  + SUM_W'(2);
        sums.dgn  = -f_sx(p[2][0]) + (f_sx(p[2][1]) <<< 2) - (f_sx(p[2][3]) <<< 2)
                  + f_sx(p[2][4]) - f_sx(p[0][2]) + (f_sx(p[1][2]) <<< 2)
                  - (f_sx(p[3][2]) <<< 2) + f_sx(p[4][2]) + SUM_W'(4);
        sums.doxn = f_sx(p[0][0]) - f_sx(p[0][2]) + f_sx(p[0][4])
                  - f_sx(p[2][0]) - (f_sx(p[2][2]) <<< 1) - f_sx(p[2][4])
                  + f_sx(p[4][0]) - f_sx(p[4][2]) + f_sx(p[4][4]) + SUM_W'(4);
        sums.hn   = f_sx(p[2][1]) + f_sx(p[2][3]) + SUM_W'(1);
        sums.vn   = f_sx(p[1][2]) + f_sx(p[3][2]) + SUM_W'(1);
        sums.dhn  = -f_sx(p[2][0]) + SUM_W'(3) * f_sx(p[2][1])
                  - SUM_W'(3) * f_sx(p[2][3]) + f_sx(p[2][4]) + SUM_W'(2);
        sums.dvn  = -f_sx(p[0][2]) + SUM_W'(3) * f_sx(p[1][2])
                  - SUM_W'(3) * f_sx(p[3][2]) + f_sx(p[4][2]) + SUM_W'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid   <= i_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_sums    <= sums;
            r_c_ctr     <= p[2][2];
            r_c_color   <= f_cfa(i_cfg.pattern, i_y[0], i_x[0]);
            r_c_red_row <= ~(i_cfg.pattern[1] ^ i_y[0]);
            r_c_method  <= i_cfg.method;
            r_c_mx      <= i_cfg.mx;
            r_c_last    <= i_last;
            r_out_word  <= n_out_word;
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] g, o, h, v, dg, dox, dh, dv;
        logic [SMP_W-1:0] gval, oval, hval, vval;
        g   = r_c_sums.gn >>> 2;
        o   = r_c_sums.on >>> 2;
        h   = r_c_sums.hn >>> 1;
        v   = r_c_sums.vn >>> 1;
        dg  = f_div_tz(r_c_sums.dgn, 3);
        dox = f_div_tz(r_c_sums.doxn, 3);
        dh  = f_div_tz(r_c_sums.dhn, 2);
        dv  = f_div_tz(r_c_sums.dvn, 2);
        if (r_c_method == METH_BILIN) begin
            gval = f_clamp(g, r_c_mx);
            oval = f_clamp(o, r_c_mx);
            hval = f_clamp(h, r_c_mx);
            vval = f_clamp(v, r_c_mx);
        end else begin
            gval = f_clamp(g + dg, r_c_mx);
            oval = f_clamp(o + dox, r_c_mx);
            hval = f_clamp(h + dh, r_c_mx);
            vval = f_clamp(v + dv, r_c_mx);
        end
        n_out_word.last_of_frame = r_c_last;
        n_out_word.red   = r_c_ctr;
        n_out_word.green = r_c_ctr;
        n_out_word.blue  = r_c_ctr;
        if (r_c_method != METH_RAW) begin
            case (r_c_color)
                CLR_R: begin
                    n_out_word.green = gval;
                    n_out_word.blue  = oval;
                end
                CLR_B: begin
                    n_out_word.green = gval;
                    n_out_word.red   = oval;
                end
                default: begin
                    n_out_word.red  = r_c_red_row ? hval : vval;
                    n_out_word.blue = r_c_red_row ? vval : hval;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

FILE: rtl/core/bayer_demosaic_bilinear_malvar_unit.sv
// Bayer demosaic top level: position counters, line store, window cell chain,
// interpolation datapath and configuration registers. Depends on bdm_pkg,
// bdm_line_store, bdm_cell and bdm_filter.
//
// Usage:
//  Input channel (i_in_valid / i_in_word / o_in_stall) takes raw samples in
//  raster order, one word per cycle. Words flagged flush are dummies that push
//  out the trailing pixels; a flush inside the frame is taken and dropped.
//  Output channel (o_out_valid / o_out_word / i_out_stall) gives one RGB word
//  per pixel; last_of_frame marks the final pixel, after which counters return
//  to zero and the next sample opens a new frame.
//  Pixel (x, y) is produced by the input word at position (x+2, y+2), i.e.
//  2*width+2 words after its own sample, then passes the pipeline stages
//  (line store read, window column, tap sums, round/clamp into output reg).
//  Throughput: one word per cycle while not stalled, set by the line store,
//  which takes one read and one write (separate ports) per word.
//  When the output register is full and i_out_stall is high the whole pipeline
//  holds and o_in_stall rises in the same cycle.
//  Reset (i_rst_n low, synchronous) clears counters, pipeline valids and loads
//  the default configuration. Config writes (i_cfg_we) are for idle periods;
//  writing width or height restarts the frame counters.
module bayer_demosaic_bilinear_malvar_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  bdm_pkg::t_in_word                 i_in_word,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output bdm_pkg::t_out_word                o_out_word,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_we,
    input  logic [bdm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bdm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bdm_pkg::*;

    // configuration
    logic [1:0]       r_pattern;
    logic [1:0]       r_method;
    logic [BITS_W-1:0] r_bits;
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;

    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic [BITS_W-1:0] b_eff;
    logic [COL_W-1:0]  w_m1;
    logic [OUT_ROW_W-1:0] h_m1;
    logic [LEAD_W-1:0] lead_max;
    t_cfg              cfg;
    logic              cfg_restart;

    // counters
    logic [COL_W-1:0]     r_in_col,  n_in_col;
    logic [IN_ROW_W-1:0]  r_in_row,  n_in_row;
    logic [COL_W-1:0]     r_out_col, n_out_col;
    logic [OUT_ROW_W-1:0] r_out_row, n_out_row;
    logic [LEAD_W-1:0]    r_lead,    n_lead;

    logic en, acc, in_frame, take, emit, last;
    logic [SMP_W-1:0] value;

    // stage A: line store read in flight
    logic                 r_a_valid;
    logic                 r_a_emit;
    logic [SMP_W-1:0]     r_a_sample;
    logic [COL_W-1:0]     r_a_col;
    logic [COL_W-1:0]     r_a_x;
    logic [OUT_ROW_W-1:0] r_a_y;
    logic                 r_a_last;

    // stage B: window holds this pixel's neighborhood
    logic                 r_b_valid;
    logic [COL_W-1:0]     r_b_x;
    logic [OUT_ROW_W-1:0] r_b_y;
    logic                 r_b_last;

    t_column  column;
    t_window  win;
    logic     f_valid;

    always_comb begin
        if (r_width == '0) begin
            w_eff = WID_W'(1);
        end else if (r_width > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = HGT_W'(1);
        end else if (r_height > HGT_W'(MAX_HEIGHT)) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
        if (r_bits == '0) begin
            b_eff = BITS_W'(1);
        end else if (r_bits > BITS_W'(MAX_BITS)) begin
            b_eff = BITS_W'(MAX_BITS);
        end else begin
            b_eff = r_bits;
        end
    end

    assign w_m1     = COL_W'(w_eff - WID_W'(1));
    assign h_m1     = OUT_ROW_W'(h_eff - HGT_W'(1));
    assign lead_max = LEAD_W'({w_eff, 1'b0}) + LEAD_W'(2);

    assign cfg.pattern = r_pattern;
    assign cfg.method  = r_method;
    assign cfg.mx      = SMP_W'((17'd1 << b_eff) - 17'd1);
    assign cfg.width   = w_eff;
    assign cfg.height  = h_eff;

    assign cfg_restart = i_cfg_we && (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT);

    assign en         = !(f_valid && i_out_stall);
    assign o_in_stall = !en;
    assign acc        = i_in_valid && en;
    assign in_frame   = r_in_row < h_eff;
    assign take       = acc && !(in_frame && i_in_word.flush);
    assign value      = in_frame ? i_in_word.sample : '0;
    assign emit       = (r_lead == lead_max);
    assign last       = emit && (r_out_col == w_m1) && (r_out_row == h_m1);

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_lead    = r_lead;
        if (cfg_restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_lead    = '0;
        end else if (take) begin
            if (r_in_col == w_m1) begin
                n_in_col = '0;
                n_in_row = r_in_row + IN_ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (emit) begin
                if (r_out_col == w_m1) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + OUT_ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end else begin
                n_lead = r_lead + LEAD_W'(1);
            end
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_lead    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= 2'd0;
            r_method  <= METH_BILIN;
            r_bits    <= BITS_W'(8);
            r_width   <= WID_W'(640);
            r_height  <= HGT_W'(480);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_lead    <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PATTERN: r_pattern <= i_cfg_data[1:0];
                    REG_METHOD:  r_method  <= i_cfg_data[1:0];
                    REG_BITS:    r_bits    <= i_cfg_data[BITS_W-1:0];
                    REG_WIDTH:   r_width   <= i_cfg_data[WID_W-1:0];
                    REG_HEIGHT:  r_height  <= i_cfg_data[HGT_W-1:0];
                    default: ;
                endcase
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_lead    <= n_lead;
            if (en) begin
                r_a_valid <= take;
                r_b_valid <= r_a_valid && r_a_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (take) begin
                r_a_sample <= value;
                r_a_col    <= r_in_col;
                r_a_emit   <= emit;
                r_a_x      <= r_out_col;
                r_a_y      <= r_out_row;
                r_a_last   <= last;
            end
            r_b_x    <= r_a_x;
            r_b_y    <= r_a_y;
            r_b_last <= r_a_last;
        end
    end

    bdm_line_store u_line_store (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_rd        (take),
        .i_rd_addr   (r_in_col),
        .i_wr        (r_a_valid),
        .i_wr_addr   (r_a_col),
        .i_wr_sample (r_a_sample),
        .o_column    (column)
    );

    // window: chain of column cells, newest column enters cell 0
    for (genvar k = 0; k < WIN_N; k++) begin : g_cell
        if (k == 0) begin : g_head
            bdm_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (en && r_a_valid),
                .i_column (column),
                .o_column (win[k])
            );
        end else begin : g_tail
            bdm_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (en && r_a_valid),
                .i_column (win[k-1]),
                .o_column (win[k])
            );
        end
    end

    bdm_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_valid),
        .i_x     (r_b_x),
        .i_y     (r_b_y),
        .i_last  (r_b_last),
        .i_win   (win),
        .i_cfg   (cfg),
        .o_valid (f_valid),
        .o_word  (o_out_word)
    );

    assign o_out_valid = f_valid;

    a_lead_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead <= lead_max)
        else $error("lead counter beyond 2*width+2");

    a_out_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_col <= w_m1)
        else $error("output column beyond width");

    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && last) |=> (r_in_col == '0 && r_in_row == '0 && r_lead == '0))
        else $error("counters not restarted after last pixel");

endmodule

FILE: tb/sv/bdm_frame_checker.sv
`timescale 1ns / 1ps
// Checker for the Bayer demosaic unit: predicts each RGB word from the accepted
// raw words and config writes, and compares. Depends on bdm_pkg.
module bdm_frame_checker
    import bdm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_word              i_in_word,
    input  logic                  i_in_stall,
    input  logic                  i_out_valid,
    input  t_out_word             i_out_word,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    logic [1:0]       pattern_q;
    logic [1:0]       method_q;
    logic [4:0]       bits_q;
    logic [WID_W-1:0] width_q;
    logic [HGT_W-1:0] height_q;

    logic [SMP_W-1:0] rows_mem [0:4*MAX_WIDTH-1];
    logic [SMP_W-1:0] recent_q [0:4];
    int in_col, in_row, out_col, out_row;
    int px_x, px_y, px_newest, px_w, px_h;
    int px_rgb [0:2];
    t_out_word pixel_q [$];
    int errors;

    function automatic int eff_width();
        if (width_q == 0) return 1;
        return (width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);
    endfunction

    function automatic int eff_height();
        if (height_q == 0) return 1;
        return (height_q > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_q);
    endfunction

    function automatic int full_scale();
        int b;
        b = (bits_q == 0) ? 1 : int'(bits_q);
        if (b > MAX_BITS) b = MAX_BITS;
        return (1 << b) - 1;
    endfunction

    function automatic t_color site_color(input int y, input int x);
        t_color c;
        c = CLR_G;
        case (pattern_q)
            2'd0: c = (y % 2 == 0) ? ((x % 2 == 0) ? CLR_R : CLR_G)
                                   : ((x % 2 == 0) ? CLR_G : CLR_B);
            2'd1: c = (y % 2 == 0) ? ((x % 2 == 0) ? CLR_G : CLR_R)
                                   : ((x % 2 == 0) ? CLR_B : CLR_G);
            2'd2: c = (y % 2 == 0) ? ((x % 2 == 0) ? CLR_B : CLR_G)
                                   : ((x % 2 == 0) ? CLR_G : CLR_R);
            default: c = (y % 2 == 0) ? ((x % 2 == 0) ? CLR_G : CLR_B)
                                      : ((x % 2 == 0) ? CLR_R : CLR_G);
        endcase
        return c;
    endfunction

    // neighbor sample, zero outside the image; the last five come from the shift regs
    function automatic int nb(input int dx, input int dy);
        int tx, ty, pos, d;
        logic [SMP_W-1:0] v;
        tx = px_x + dx;
        ty = px_y + dy;
        if (tx < 0 || ty < 0 || tx >= px_w || ty >= px_h) return 0;
        pos = ty * px_w + tx;
        d = px_newest - pos;
        if (d >= 0 && d < 5) v = recent_q[d];
        else v = rows_mem[(ty % 4) * MAX_WIDTH + tx];
        return int'(v) & full_scale();
    endfunction

    function automatic int sat(input int v, input int mx);
        if (v < 0) return 0;
        return (v > mx) ? mx : v;
    endfunction

    function automatic void interpolate();
        int mx, c, ctr, other, g, o, dg, dox, hi, vi, h, v, dh, dv;
        bit red_row;
        mx  = full_scale();
        c   = int'(site_color(px_y, px_x));
        ctr = nb(0, 0);
        if (method_q == METH_RAW) begin
            px_rgb[0] = ctr; px_rgb[1] = ctr; px_rgb[2] = ctr;
        end else if (c != int'(CLR_G)) begin
            other = 2 - c;
            g = (nb(-1, 0) + nb(1, 0) + nb(0, -1) + nb(0, 1) + 2) / 4;
            o = (nb(-1, -1) + nb(1, -1) + nb(-1, 1) + nb(1, 1) + 2) / 4;
            px_rgb[c] = ctr;
            if (method_q == METH_BILIN) begin
                px_rgb[1] = (g > mx) ? mx : g;
                px_rgb[other] = (o > mx) ? mx : o;
            end else begin
                dg = (-nb(-2, 0) + 4 * nb(-1, 0) - 4 * nb(1, 0) + nb(2, 0)
                      - nb(0, -2) + 4 * nb(0, -1) - 4 * nb(0, 1) + nb(0, 2) + 4) / 8;
                dox = (nb(-2, -2) - nb(0, -2) + nb(2, -2)
                       - nb(-2, 0) - 2 * ctr - nb(2, 0)
                       + nb(-2, 2) - nb(0, 2) + nb(2, 2) + 4) / 8;
                px_rgb[1] = sat(g + dg, mx);
                px_rgb[other] = sat(o + dox, mx);
            end
        end else begin
            red_row = (pattern_q < 2) ? (px_y % 2 == 0) : (px_y % 2 == 1);
            hi = red_row ? 0 : 2;
            vi = 2 - hi;
            h = (nb(-1, 0) + nb(1, 0) + 1) / 2;
            v = (nb(0, -1) + nb(0, 1) + 1) / 2;
            px_rgb[1] = ctr;
            if (method_q == METH_BILIN) begin
                px_rgb[hi] = (h > mx) ? mx : h;
                px_rgb[vi] = (v > mx) ? mx : v;
            end else begin
                dh = (-nb(-2, 0) + 3 * nb(-1, 0) - 3 * nb(1, 0) + nb(2, 0) + 2) / 4;
                dv = (-nb(0, -2) + 3 * nb(0, -1) - 3 * nb(0, 1) + nb(0, 2) + 2) / 4;
                px_rgb[hi] = sat(h + dh, mx);
                px_rgb[vi] = sat(v + dv, mx);
            end
        end
    endfunction

    task automatic take_word(input t_in_word w);
        int wd, ht, total, nxt, p, e;
        logic [SMP_W-1:0] v;
        t_out_word px;
        wd = eff_width();
        ht = eff_height();
        total = wd * ht;
        nxt = in_row * wd + in_col;
        if (nxt < total && w.flush) return;   // flush inside the frame is dropped
        v = (nxt < total) ? w.sample : '0;
        if (nxt >= 5) begin
            e = nxt - 5;
            if (e < total) rows_mem[((e / wd) % 4) * MAX_WIDTH + e % wd] = recent_q[4];
        end
        for (int k = 4; k > 0; k--) recent_q[k] = recent_q[k-1];
        recent_q[0] = v;
        in_col++;
        if (in_col >= wd) begin
            in_col = 0;
            in_row++;
        end
        p = out_row * wd + out_col;
        if (nxt < p + 2 * wd + 2) return;
        px_x = out_col; px_y = out_row; px_newest = nxt; px_w = wd; px_h = ht;
        interpolate();
        px.red = px_rgb[0][15:0];
        px.green = px_rgb[1][15:0];
        px.blue = px_rgb[2][15:0];
        px.last_of_frame = (p == total - 1);
        pixel_q.push_back(px);
        out_col++;
        if (out_col >= wd) begin
            out_col = 0;
            out_row++;
        end
        if (px.last_of_frame) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            pattern_q = 2'd0;
            method_q = 2'd1;
            bits_q = 5'd8;
            width_q = 12'd640;
            height_q = 13'd480;
            for (int k = 0; k < 5; k++) recent_q[k] = '0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            pixel_q.delete();
            errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PATTERN: pattern_q = i_cfg_data[1:0];
                    REG_METHOD:  method_q = i_cfg_data[1:0];
                    REG_BITS:    bits_q = i_cfg_data[4:0];
                    REG_WIDTH: begin
                        width_q = i_cfg_data[WID_W-1:0];
                        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                    end
                    REG_HEIGHT: begin
                        height_q = i_cfg_data[HGT_W-1:0];
                        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) take_word(i_in_word);
            if (i_out_valid && !i_out_stall) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected output word %h", i_out_word);
                    errors++;
                end else begin
                    want = pixel_q.pop_front();
                    if (i_out_word.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, i_out_word.red);
                        errors++;
                    end
                    if (i_out_word.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, i_out_word.green);
                        errors++;
                    end
                    if (i_out_word.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, i_out_word.blue);
                        errors++;
                    end
                    if (i_out_word.last_of_frame !== want.last_of_frame) begin
                        $error("last_of_frame: expected %0d, got %0d",
                               want.last_of_frame, i_out_word.last_of_frame);
                        errors++;
                    end
                end
            end
        end
        o_errors = errors;
        o_pending = pixel_q.size();
    end

endmodule

FILE: tb/sv/tb_bayer_demosaic_bilinear_malvar_unit.sv
`timescale 1ns / 1ps
// Testbench top for the Bayer demosaic unit: clock, reset, frame stimulus with
// random gaps and output stalls. Depends on bdm_pkg and bdm_frame_checker.
module tb_bayer_demosaic_bilinear_malvar_unit;
    import bdm_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    t_in_word              in_word;
    logic                  in_stall;
    logic                  out_valid;
    t_out_word             out_word;
    logic                  out_stall;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    bit                    quiet;
    int                    words_sent;

    bayer_demosaic_bilinear_malvar_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bdm_frame_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .i_in_stall  (in_stall),
        .i_out_valid (out_valid),
        .i_out_word  (out_word),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    // receiver: random stall before each word
    initial begin
        int gap;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            gap = draw_gap();
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send(input logic [SMP_W-1:0] smp, input logic fl);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= '{sample: smp, flush: fl};
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // hold the input until every pixel is out, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SMP_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return SMP_W'($urandom_range(0, 255));
            default: return SMP_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_modes();
        int b;
        case ($urandom_range(0, 6))
            0: b = 0;
            1: b = 1;
            2: b = 16;
            3: b = 31;
            4: b = 8;
            default: b = $urandom_range(2, 17);
        endcase
        cfg_write(REG_PATTERN, $urandom_range(0, 3));
        cfg_write(REG_METHOD, $urandom_range(0, 3));
        cfg_write(REG_BITS, b);
    endtask

    // one frame of we x he raw words (effective size), then the trailing flush words
    task automatic run_frame(input int wr, input int hr, input int we, input int he);
        int pause_at;
        pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, we * he - 1) : -1;
        cfg_write(REG_WIDTH, wr);
        cfg_write(REG_HEIGHT, hr);
        for (int k = 0; k < we * he; k++) begin
            if (k == pause_at) begin
                drain();
                cfg_write(REG_METHOD, $urandom_range(0, 3));
                cfg_write(REG_PATTERN, $urandom_range(0, 3));
            end
            if ($urandom_range(0, 15) == 0) send(draw_sample(), 1'b1);
            send(draw_sample(), 1'b0);
        end
        for (int k = 0; k < 2 * we + 2; k++) begin
            // a sample past the frame end pushes like a flush
            send(draw_sample(), $urandom_range(0, 1));
        end
        if ($urandom_range(0, 3) == 0) send(draw_sample(), 1'b1);
        drain();
    endtask

    initial begin
        int w, h;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        words_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: tiny frame, full-scale checkerboard, gradient mode
        cfg_write(REG_PATTERN, 0);
        cfg_write(REG_METHOD, 2);
        cfg_write(REG_BITS, 16);
        cfg_write(REG_WIDTH, 3);
        cfg_write(REG_HEIGHT, 2);
        send(16'hFFFF, 1'b0);
        send(16'h0000, 1'b0);
        send(16'h0000, 1'b1);
        send(16'hFFFF, 1'b0);
        send(16'h0000, 1'b0);
        send(16'hFFFF, 1'b0);
        send(16'h0000, 1'b0);
        for (int k = 0; k < 8; k++) send(16'hA5A5, k[0]);
        send(16'h1234, 1'b1);
        drain();

        // register extremes: zero width, zero height, out-of-range bits
        cfg_write(REG_METHOD, 3);
        cfg_write(REG_BITS, 0);
        run_frame(0, 2, 1, 2);
        cfg_write(REG_BITS, 31);
        cfg_write(REG_METHOD, 0);
        run_frame(3, 0, 3, 1);

        while (words_sent < 800) begin
            quiet = ($urandom_range(0, 4) == 0);
            random_modes();
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            run_frame(w, h, w, h);
        end
        quiet = 1'b0;
        drain();

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
